[design/b64d_pkg.sv]
`default_nettype none
package b64d_pkg;

   localparam logic [7:0] CharPad   = 8'h3D;  // '='
   localparam logic [7:0] CharLf    = 8'h0A;
   localparam logic [7:0] CharCr    = 8'h0D;
   localparam logic [7:0] CharSpace = 8'h20;
   localparam logic [7:0] CharPlus  = 8'h2B;
   localparam logic [7:0] CharSlash = 8'h2F;
   localparam logic [7:0] CharUpA   = 8'h41;
   localparam logic [7:0] CharUpZ   = 8'h5A;
   localparam logic [7:0] CharLoA   = 8'h61;
   localparam logic [7:0] CharLoZ   = 8'h7A;
   localparam logic [7:0] CharDig0  = 8'h30;
   localparam logic [7:0] CharDig9  = 8'h39;

   localparam int QueueDepth = 4;
   localparam int QueueAw    = $clog2(QueueDepth);

   typedef struct packed {
      logic [2:0][7:0] bytes;  // bytes[0] is the first byte of the group
      logic [2:0]      keep;
   } group_type;

   typedef struct packed {
      logic      avail;
      group_type group;
   } queue_head_type;

   typedef struct packed {
      logic       bad;
      logic [5:0] value;
   } sextet_type;

   function automatic sextet_type sextet_of(input logic [7:0] c);
      sextet_type r;
      r.bad   = 1'b0;
      r.value = 6'd0;
      if (c >= CharUpA && c <= CharUpZ) begin
         r.value = 6'(c - CharUpA);
      end else if (c >= CharLoA && c <= CharLoZ) begin
         r.value = 6'(c - CharLoA) + 6'd26;
      end else if (c >= CharDig0 && c <= CharDig9) begin
         r.value = 6'(c - CharDig0) + 6'd52;
      end else if (c == CharPlus) begin
         r.value = 6'd62;
      end else if (c == CharSlash) begin
         r.value = 6'd63;
      end else if (c == CharPad) begin
         r.value = 6'd0;
      end else begin
         r.bad = 1'b1;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

[design/b64d_front.sv]
`default_nettype none
module b64d_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [7:0]         req_char_code,
   input  wire logic               req_end_of_text,
   input  wire logic               queue_full,
   output logic                    push,
   output b64d_pkg::group_type     push_group
);
   import b64d_pkg::*;

   logic [1:0]  pos_ff, pos_in;
   logic [17:0] held_ff, held_in;
   logic        pad3_ff, pad3_in;
   logic        inval_ff, inval_in;
   logic        halted_ff, halted_in;

   logic        accept;
   logic        is_space;
   sextet_type  sx;
   logic [5:0]  s0, s1, s2;

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;
   assign is_space  = (req_char_code == CharLf) || (req_char_code == CharCr)
                      || (req_char_code == CharSpace);
   assign sx = sextet_of(req_char_code);
   assign s0 = held_ff[17:12];
   assign s1 = held_ff[11:6];
   assign s2 = held_ff[5:0];

   always_comb begin
      pos_in     = pos_ff;
      held_in    = held_ff;
      pad3_in    = pad3_ff;
      inval_in   = inval_ff;
      halted_in  = halted_ff;
      push       = 1'b0;
      push_group.bytes[0] = {s0, s1[5:4]};
      push_group.bytes[1] = {s1[3:0], s2[5:2]};
      push_group.bytes[2] = {s2[1:0], sx.value};
      push_group.keep     = {req_char_code != CharPad, !pad3_ff, 1'b1};
      if (accept) begin
         if (!halted_ff && !is_space) begin
            if (pos_ff != 2'd3) begin
               if (sx.bad) inval_in = 1'b1;
               if (pos_ff == 2'd2) pad3_in = (req_char_code == CharPad);
               held_in = {held_ff[11:0], sx.value};
               pos_in  = pos_ff + 2'd1;
            end else begin
               if (inval_ff || sx.bad) begin
                  halted_in = 1'b1;
               end else begin
                  push = 1'b1;
               end
               pos_in   = 2'd0;
               held_in  = 18'd0;
               pad3_in  = 1'b0;
               inval_in = 1'b0;
            end
         end
         if (req_end_of_text) begin
            pos_in    = 2'd0;
            held_in   = 18'd0;
            pad3_in   = 1'b0;
            inval_in  = 1'b0;
            halted_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= 2'd0;
         held_ff   <= 18'd0;
         pad3_ff   <= 1'b0;
         inval_ff  <= 1'b0;
         halted_ff <= 1'b0;
      end else begin
         pos_ff    <= pos_in;
         held_ff   <= held_in;
         pad3_ff   <= pad3_in;
         inval_ff  <= inval_in;
         halted_ff <= halted_in;
      end
   end

endmodule
`default_nettype wire

[design/b64d_queue.sv]
`default_nettype none
module b64d_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire b64d_pkg::group_type    push_group,
   output logic                        full,
   input  wire logic                   pop,
   output b64d_pkg::queue_head_type    head
);
   import b64d_pkg::*;

   group_type            mem [QueueDepth];
   logic [QueueAw-1:0]   wr_ff, wr_in;
   logic [QueueAw-1:0]   rd_ff, rd_in;
   logic [QueueAw:0]     count_ff, count_in;

   assign full       = (count_ff == (QueueAw+1)'(QueueDepth));
   assign head.avail = (count_ff != '0);
   assign head.group = mem[rd_ff];

   always_comb begin
      wr_in    = push ? wr_ff + 1'b1 : wr_ff;
      rd_in    = pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff + (QueueAw+1)'(push) - (QueueAw+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) mem[wr_ff] <= push_group;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

[design/b64d_back.sv]
`default_nettype none
module b64d_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire b64d_pkg::queue_head_type head,
   output logic                         pop,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [7:0]                   rsp_data_byte,
   output logic                         rsp_last_of_group
);
   import b64d_pkg::*;

   logic [2:0][7:0] bytes_ff, bytes_in;
   logic [2:0]      keep_ff, keep_in;
   logic [2:0]      rest;
   logic            accept;

   // keep_ff marks the bytes of the current group still to be sent
   assign rest              = keep_ff & (keep_ff - 3'd1);
   assign rsp_valid         = (keep_ff != 3'd0);
   assign rsp_last_of_group = (rest == 3'd0);
   assign accept            = rsp_valid && !rsp_stall;
   assign pop               = head.avail && (!rsp_valid || (accept && rsp_last_of_group));

   always_comb begin
      if (keep_ff[0]) begin
         rsp_data_byte = bytes_ff[0];
      end else if (keep_ff[1]) begin
         rsp_data_byte = bytes_ff[1];
      end else begin
         rsp_data_byte = bytes_ff[2];
      end
   end

   always_comb begin
      bytes_in = bytes_ff;
      keep_in  = keep_ff;
      if (accept) keep_in = rest;
      if (pop) begin
         bytes_in = head.group.bytes;
         keep_in  = head.group.keep;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_ff <= 3'd0;
      end else begin
         keep_ff <= keep_in;
      end
   end

endmodule
`default_nettype wire

[design/base64_stream_decoder_core.sv]
// base64 stream decoder
//
// req channel: one character per transaction (req_char_code) with
// req_end_of_text marking the last character of a text. whitespace is
// skipped; each completed group of four characters yields one to three
// bytes on the rsp channel, rsp_last_of_group set on the final one.
// a group holding an invalid character gives nothing and the decoder
// ignores input until the end-of-text transaction.
//
// throughput: one character per cycle while req_stall is low; the back end
// sends one byte per cycle while rsp_stall is low, so three bytes on the rsp
// port keep pace with the four characters of their group. the first byte of a
// group shows on rsp after the fourth character is taken, by way of the queue
// write, then the load of the output group register.
//
// a four-entry group queue sits between the character front end and the
// byte sender. when the receiver holds rsp_stall the queue fills and then
// req_stall rises; the output byte and flags hold while stalled.
// reset (synchronous) empties the queue and clears the group and halt state.
`default_nettype none
module base64_stream_decoder_core (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_char_code,
   input  wire logic       req_end_of_text,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_data_byte,
   output logic            rsp_last_of_group
);
   import b64d_pkg::*;

   logic           queue_full;
   logic           push;
   logic           pop;
   group_type      push_group;
   queue_head_type head;

   b64d_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_char_code   (req_char_code),
      .req_end_of_text (req_end_of_text),
      .queue_full      (queue_full),
      .push            (push),
      .push_group      (push_group)
   );

   b64d_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_group (push_group),
      .full       (queue_full),
      .pop        (pop),
      .head       (head)
   );

   b64d_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_last_of_group (rsp_last_of_group)
   );

endmodule
`default_nettype wire

[design/b64d_checker.sv]
`default_nettype none
module b64d_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_data_byte,
   input wire logic       rsp_last_of_group
);

   // stalled result must stay offered
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   a_rsp_stable : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data_byte) && $stable(rsp_last_of_group))
      else $error("rsp payload changed while stalled");

   // after reset nothing is pending and input is taken
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not empty after reset");

   // the rest of a group is already held when a non-final byte is taken
   a_group_follows : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_of_group |=> rsp_valid)
      else $error("gap inside a group");

endmodule

bind base64_stream_decoder_core b64d_checker u_chk (.*);
`default_nettype wire

[bench/tb_base64_stream_decoder_core.sv]
`default_nettype none
module tb_base64_stream_decoder_core;
   timeunit 1ns;
   timeprecision 1ps;

   import b64d_pkg::*;

   localparam int ItemTarget  = 280;
   localparam int LongHold    = 150;
   localparam int CycleLimit  = 200000;
   localparam int DrainCycles = 20;

   typedef enum int {RxFree, RxRandom, RxPattern, RxLongHold} rx_mode_type;

   class b64_scoreboard;
      typedef struct packed {
         logic [7:0] data_byte;
         logic       last_of_group;
      } out_byte_type;

      out_byte_type byte_queue[$];
      bit [1:0]   group_pos;
      bit [17:0]  held;
      bit         third_pad;
      bit         group_bad;
      bit         halted;
      int         errors;
      int         bytes_seen;
      int         groups_out;
      int         groups_bad;

      // returns 1 for a base64 character or pad, v is 0 for pad and invalid codes
      static function bit char_sextet(input bit [7:0] c, output bit [5:0] v);
         v = 6'd0;
         if (c >= CharUpA && c <= CharUpZ) v = 6'(c - CharUpA);
         else if (c >= CharLoA && c <= CharLoZ) v = 6'(c - CharLoA + 26);
         else if (c >= CharDig0 && c <= CharDig9) v = 6'(c - CharDig0 + 52);
         else if (c == CharPlus) v = 6'd62;
         else if (c == CharSlash) v = 6'd63;
         else if (c != CharPad) return 1'b0;
         return 1'b1;
      endfunction

      function void clear_group();
         group_pos = 2'd0;
         held      = 18'd0;
         third_pad = 1'b0;
         group_bad = 1'b0;
      endfunction

      // returns 1 when the character takes part in decoding
      function bit note_char(input bit [7:0] c, input bit eot);
         bit [5:0]  v;
         bit        bad;
         bit        consumed;
         bit [5:0]  s0, s1, s2;
         bit [7:0]  b [3];
         bit        keep [3];
         int        last_idx;
         out_byte_type e;
         consumed = !halted && c != CharLf && c != CharCr && c != CharSpace;
         if (consumed) begin
            bad = !char_sextet(c, v);
            if (group_pos != 2'd3) begin
               if (bad) group_bad = 1'b1;
               if (group_pos == 2'd2) third_pad = (c == CharPad);
               held = {held[11:0], v};
               group_pos = group_pos + 2'd1;
            end else begin
               if (group_bad || bad) begin
                  halted = 1'b1;
                  groups_bad++;
               end else begin
                  s0 = held[17:12];
                  s1 = held[11:6];
                  s2 = held[5:0];
                  b[0] = {s0, s1[5:4]};
                  b[1] = {s1[3:0], s2[5:2]};
                  b[2] = {s2[1:0], v};
                  keep[0] = 1'b1;
                  keep[1] = !third_pad;
                  keep[2] = (c != CharPad);
                  last_idx = keep[2] ? 2 : (keep[1] ? 1 : 0);
                  for (int k = 0; k < 3; k++) begin
                     if (keep[k]) begin
                        e.data_byte     = b[k];
                        e.last_of_group = (k == last_idx);
                        byte_queue = {byte_queue, e};
                     end
                  end
                  groups_out++;
               end
               clear_group();
            end
         end
         if (eot) begin
            clear_group();
            halted = 1'b0;
         end
         return consumed;
      endfunction

      function void check_byte(input logic [7:0] d, input logic last);
         out_byte_type e;
         if (byte_queue.size() == 0) begin
            $display("%0t: unexpected byte: expected none, actual %02h last_of_group %0b",
                     $time, d, last);
            errors++;
            return;
         end
         e = byte_queue.pop_front();
         bytes_seen++;
         if (d !== e.data_byte) begin
            $display("%0t: data_byte mismatch: expected %02h, actual %02h",
                     $time, e.data_byte, d);
            errors++;
         end
         if (last !== e.last_of_group) begin
            $display("%0t: last_of_group mismatch: expected %0b, actual %0b",
                     $time, e.last_of_group, last);
            errors++;
         end
      endfunction
   endclass

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_char_code = 8'h00;
   logic       req_end_of_text = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_data_byte;
   logic       rsp_last_of_group;

   b64_scoreboard sb = new();
   rx_mode_type   rx_mode = RxFree;
   bit            gaps_on = 1'b0;
   int            burst_left = 1;
   int            chars_sent = 0;
   int            consumed_count = 0;

   base64_stream_decoder_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_char_code     (req_char_code),
      .req_end_of_text   (req_end_of_text),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_last_of_group (rsp_last_of_group)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit [7:0] sextet_char(input bit [5:0] v);
      if (v < 26) return CharUpA + 8'(v);
      if (v < 52) return CharLoA + 8'(v - 26);
      if (v < 62) return CharDig0 + 8'(v - 52);
      return (v == 6'd62) ? CharPlus : CharSlash;
   endfunction

   function automatic bit [7:0] blank_char();
      case ($urandom_range(0, 2))
         0: return CharLf;
         1: return CharCr;
         default: return CharSpace;
      endcase
   endfunction

   function automatic bit [7:0] bad_char();
      bit [7:0] c;
      bit [5:0] v;
      do begin
         c = 8'($urandom_range(0, 255));
      end while (b64_scoreboard::char_sextet(c, v) ||
                 c == CharLf || c == CharCr || c == CharSpace);
      return c;
   endfunction

   task automatic send_char(input bit [7:0] c, input bit eot);
      req_valid       <= 1'b1;
      req_char_code   <= c;
      req_end_of_text <= eot;
      do @(posedge clock); while (req_stall !== 1'b0);
      chars_sent++;
      if (sb.note_char(c, eot)) consumed_count++;
      if (gaps_on) begin
         burst_left--;
         if (burst_left <= 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            burst_left = $urandom_range(1, 16);
         end
      end
   endtask

   task automatic send_str(input string s, input bit eot_last);
      for (int i = 0; i < s.len(); i++)
         send_char(s[i], eot_last && i == s.len() - 1);
   endtask

   // sender pauses until every expected byte is back
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.byte_queue.size() != 0);
   endtask

   task automatic send_text(input int min_groups, input int max_groups, input bit allow_bad);
      bit [7:0] txt[$];
      int       groups;
      int       pads;
      int       r;
      bit [7:0] c;
      if (allow_bad && $urandom_range(0, 9) == 0) begin
         // noise: raw bytes with scattered end-of-text marks
         repeat ($urandom_range(1, 8))
            send_char(8'($urandom_range(0, 255)), $urandom_range(0, 4) == 0);
         return;
      end
      groups = $urandom_range(min_groups, max_groups);
      pads = ($urandom_range(0, 9) < 3) ? $urandom_range(1, 2) : 0;
      for (int g = 0; g < groups; g++) begin
         for (int p = 0; p < 4; p++) begin
            if ($urandom_range(0, 99) < 8) txt = {txt, blank_char()};
            r = $urandom_range(0, 99);
            if (allow_bad && r < 3) c = bad_char();
            else if (r < 6) c = CharPad;
            else c = sextet_char(6'($urandom_range(0, 63)));
            if (g == groups - 1 && p >= 4 - pads) c = CharPad;
            txt = {txt, c};
         end
      end
      if ($urandom_range(0, 99) < 15)
         repeat ($urandom_range(1, 3)) txt = {txt, sextet_char(6'($urandom_range(0, 63)))};
      if ($urandom_range(0, 9) == 0) txt = {txt, blank_char()};
      foreach (txt[i]) send_char(txt[i], i == txt.size() - 1);
   endtask

   // result side: check accepted bytes, then pick the next stall value
   initial begin
      int hold_cnt;
      int pat_cnt;
      hold_cnt = 0;
      pat_cnt = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0)
            sb.check_byte(rsp_data_byte, rsp_last_of_group);
         case (rx_mode)
            RxFree: rsp_stall <= 1'b0;
            RxRandom: rsp_stall <= ($urandom_range(0, 99) < 35);
            RxPattern: begin
               pat_cnt++;
               rsp_stall <= (pat_cnt % 5) >= 3;
            end
            RxLongHold: begin
               if (hold_cnt < LongHold) begin
                  hold_cnt++;
                  rsp_stall <= 1'b1;
               end else begin
                  hold_cnt = 0;
                  rx_mode = RxRandom;
                  rsp_stall <= 1'b0;
               end
            end
            default: rsp_stall <= 1'b0;
         endcase
      end
   end

   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CycleLimit) begin
         @(posedge clock);
         cycles++;
      end
      $display("%0t: cycle limit reached, %0d bytes still expected",
               $time, sb.byte_queue.size());
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      bit pressure_done;
      pressure_done = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_str("TW Fu", 1'b0);     // full group, space skipped
      send_str("TQ\n==", 1'b0);    // single byte, line feed skipped
      send_str("+/9\rz", 1'b0);    // top sextets, carriage return skipped
      send_str("=A=B", 1'b0);      // pad first, pad third with data fourth
      send_str("T=E=", 1'b0);      // pad second, two bytes
      send_str("A", 1'b0);
      send_char(8'hFF, 1'b0);      // invalid inside the group
      send_str("AA", 1'b0);        // group completes and halts
      send_char(8'h00, 1'b1);      // ignored while halted, end of text clears
      send_str("Q", 1'b0);
      send_char(CharLf, 1'b1);     // partial group dropped, end on whitespace
      drain();

      gaps_on = 1'b1;
      rx_mode = RxRandom;
      while (chars_sent < ItemTarget) begin
         if (!pressure_done && chars_sent > 100) begin
            // receiver holds off while the sender keeps the input busy
            drain();
            gaps_on = 1'b0;
            rx_mode = RxLongHold;
            send_text(8, 8, 1'b0);
            drain();
            pressure_done = 1'b1;
            gaps_on = 1'b1;
         end
         if ($urandom_range(0, 4) == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 2));
            gaps_on = $urandom_range(0, 3) != 0;
         end
         if ($urandom_range(0, 19) == 0) drain();
         send_text(1, 5, 1'b1);
      end

      drain();
      repeat (DrainCycles) @(posedge clock);
      $display("sent %0d characters, %0d of them decoded, with random gaps and stalls",
               chars_sent, consumed_count);
      $display("checked %0d bytes from %0d groups, %0d invalid groups halted the decoder",
               sb.bytes_seen, sb.groups_out, sb.groups_bad);
      if (sb.errors == 0 && sb.byte_queue.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
`default_nettype wire
